FILE: rtl/idxrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idxrd_pkg;

    // Number of digit positions produced for every index, clamped to 1..64.
    localparam int NUM_DIGITS = 8;
    localparam int RUN_LEN    = (NUM_DIGITS < 1) ? 1 : ((NUM_DIGITS > 64) ? 64 : NUM_DIGITS);

    localparam int IDX_W   = 31;
    localparam int RADIX_W = 8;
    localparam int POS_W   = 6;

    // The divider retires DIV_BITS quotient bits per cycle.
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = (IDX_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W      = DIV_STEPS * DIV_BITS;
    localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RUN_LEN - 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

    // Configuration register addresses.
    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_RADIX = PADDR_W'(0);

endpackage

`default_nettype wire

FILE: rtl/index_to_radix_digits_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Splits a 31-bit index into NUM_DIGITS digits of the configured radix,
// least significant digit first.
// Command channel: an index is taken on a rising edge where start is high
// and busy is low. busy stays high until the last digit has been issued.
// Result channel: each digit appears for exactly one cycle with result_valid
// high, together with its position, last_digit on the final position and
// overflow_flag on that final position when the index did not fit.
// The receiver cannot stall the block; results are simply issued.
// Operation: every digit costs one pass through the shared divider, which
// retires four quotient bits per cycle; each new pass divides the quotient
// of the previous one, and a new index is accepted only after busy has
// dropped with the last digit.
// Configuration: one APB register at address 0 holds the radix (reset 2);
// values 0 and 1 act as 2. Write it only while busy is low.
// Reset returns the block to idle with no result pending.
module index_to_radix_digits_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [idxrd_pkg::IDX_W-1:0]         index_value,
    output logic                                     result_valid,
    output logic [idxrd_pkg::RADIX_W-1:0]            digit_value,
    output logic [idxrd_pkg::POS_W-1:0]              digit_position,
    output logic                                     last_digit,
    output logic                                     overflow_flag,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [idxrd_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic [idxrd_pkg::RADIX_W-1:0]      radix_reg;
    logic [idxrd_pkg::RADIX_W-1:0]      radix_next;
    logic [idxrd_pkg::POS_W-1:0]        pos_reg;
    logic [idxrd_pkg::POS_W-1:0]        pos_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic [idxrd_pkg::RADIX_W-1:0]      digit_reg;
    logic [idxrd_pkg::POS_W-1:0]        dpos_reg;
    logic                               last_reg;
    logic                               ovf_reg;
    logic                               accept;
    logic                               is_last;
    logic                               div_start;
    logic [idxrd_pkg::DIV_W-1:0]        div_dividend;
    logic [idxrd_pkg::RADIX_W-1:0]      div_divisor;
    logic                               div_done;
    logic [idxrd_pkg::DIV_W-1:0]        div_quotient;
    logic [idxrd_pkg::RADIX_W-1:0]      div_remainder;
    logic                               cfg_write;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign is_last = (pos_reg == idxrd_pkg::LAST_POS);

    assign div_divisor = (radix_reg < idxrd_pkg::RADIX_MIN) ? idxrd_pkg::RADIX_MIN : radix_reg;
    assign div_start   = accept || ((state_reg == ST_RUN) && div_done && !is_last);
    assign div_dividend = accept
        ? idxrd_pkg::DIV_W'(index_value)
        : div_quotient;

    idxrd_divider u_divider
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder)
    );

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    pos_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (div_done)
                begin
                    valid_next = 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_write  = psel && penable && pwrite && pready;
    assign radix_next = (cfg_write && (paddr == idxrd_pkg::ADDR_RADIX))
        ? pwdata[idxrd_pkg::RADIX_W-1:0]
        : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
            radix_reg <= idxrd_pkg::RADIX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
            radix_reg <= radix_next;
        end
    end

    // Result payload; the quotient left after the last digit is the overflow.
    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            digit_reg <= div_remainder;
            dpos_reg  <= pos_reg;
            last_reg  <= is_last;
            ovf_reg   <= is_last && (div_quotient != '0);
        end
    end

    assign result_valid   = valid_reg;
    assign digit_value    = digit_reg;
    assign digit_position = dpos_reg;
    assign last_digit     = last_reg;
    assign overflow_flag  = ovf_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == idxrd_pkg::ADDR_RADIX) ? {24'b0, radix_reg} : 32'b0;

endmodule

`default_nettype wire

FILE: rtl/idxrd_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module idxrd_divider
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  div_start,
    input  wire logic [idxrd_pkg::DIV_W-1:0]           div_dividend,
    input  wire logic [idxrd_pkg::RADIX_W-1:0]         div_divisor,
    output logic                                       div_done,
    output logic [idxrd_pkg::DIV_W-1:0]                div_quotient,
    output logic [idxrd_pkg::RADIX_W-1:0]              div_remainder
);

    logic                                   run_reg;
    logic                                   run_next;
    logic                                   done_reg;
    logic                                   done_next;
    logic [idxrd_pkg::DIV_CNT_W-1:0]        cnt_reg;
    logic [idxrd_pkg::DIV_CNT_W-1:0]        cnt_next;
    logic [idxrd_pkg::DIV_W-1:0]            work_reg;
    logic [idxrd_pkg::DIV_W-1:0]            work_next;
    logic [idxrd_pkg::RADIX_W-1:0]          rem_reg;
    logic [idxrd_pkg::RADIX_W-1:0]          rem_next;
    logic [idxrd_pkg::RADIX_W-1:0]          divisor_reg;
    logic [idxrd_pkg::RADIX_W-1:0]          divisor_next;
    logic [idxrd_pkg::RADIX_W-1:0]          step_rem;
    logic [idxrd_pkg::DIV_BITS-1:0]         step_q;

    // Restoring division, several bits per cycle. The partial remainder stays
    // below the divisor, so one extra bit of headroom is enough.
    always_comb
    begin
        logic [idxrd_pkg::RADIX_W:0] r;
        r      = {1'b0, rem_reg};
        step_q = '0;
        for (int i = 0; i < idxrd_pkg::DIV_BITS; i++)
        begin
            r = {r[idxrd_pkg::RADIX_W-1:0], work_reg[idxrd_pkg::DIV_W-1-i]};
            if (r >= {1'b0, divisor_reg})
            begin
                r = r - {1'b0, divisor_reg};
                step_q[idxrd_pkg::DIV_BITS-1-i] = 1'b1;
            end
        end
        step_rem = r[idxrd_pkg::RADIX_W-1:0];
    end

    always_comb
    begin
        run_next     = run_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (div_start)
        begin
            run_next     = 1'b1;
            cnt_next     = '0;
            work_next    = div_dividend;
            rem_next     = '0;
            divisor_next = div_divisor;
        end
        else if (run_reg)
        begin
            work_next = {work_reg[idxrd_pkg::DIV_W-idxrd_pkg::DIV_BITS-1:0], step_q};
            rem_next  = step_rem;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == idxrd_pkg::DIV_CNT_W'(idxrd_pkg::DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign div_done      = done_reg;
    assign div_quotient  = work_reg;
    assign div_remainder = rem_reg;

endmodule

`default_nettype wire

FILE: dv/radix_digit_checker.sv
`timescale 1ns / 1ps

module radix_digit_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [idxrd_pkg::IDX_W-1:0]   index_value,
    input  wire logic                          result_valid,
    input  wire logic [idxrd_pkg::RADIX_W-1:0] digit_value,
    input  wire logic [idxrd_pkg::POS_W-1:0]   digit_position,
    input  wire logic                          last_digit,
    input  wire logic                          overflow_flag,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [idxrd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    input  wire logic                          pready,
    output int                                 outstanding,
    output int                                 mismatches
);
    import idxrd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [RADIX_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic               last;
        logic               overflow;
    } digit_t;

    digit_t             digits_due[$];
    digit_t             want;
    digit_t             got;
    logic [RADIX_W-1:0] radix_cfg = RADIX_RESET;
    int                 error_cnt = 0;

    // Repeated division, lowest digit first; whatever quotient survives the
    // last position means the index did not fit.
    function automatic void expand_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0]   quotient;
        logic [RADIX_W-1:0] base;
        digit_t             d;
        base = (radix_cfg < RADIX_MIN) ? RADIX_MIN : radix_cfg;
        quotient = idx;
        for (int pos = 0; pos < RUN_LEN; pos++)
        begin
            d.value    = RADIX_W'(quotient % IDX_W'(base));
            quotient   = quotient / IDX_W'(base);
            d.position = POS_W'(pos);
            d.last     = (pos == RUN_LEN - 1);
            d.overflow = d.last && (quotient != '0);
            digits_due.push_back(d);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_cfg = RADIX_RESET;
            digits_due.delete();
            outstanding <= 0;
            mismatches <= error_cnt;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RADIX)
                radix_cfg = pwdata[RADIX_W-1:0];

            // A digit seen at the same edge as a new transaction belongs to an
            // earlier index, so compare before queueing the new run.
            if (result_valid)
            begin
                got = '{digit_value, digit_position, last_digit, overflow_flag};
                if (digits_due.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= REPORT_LIMIT)
                        $display("digit check failed: unexpected digit %0d at position %0d",
                                 digit_value, digit_position);
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (got !== want)
                    begin
                        error_cnt++;
                        if (error_cnt <= REPORT_LIMIT)
                            $display({"digit check failed: expected value %0d pos %0d ",
                                      "last %0b ovf %0b, got value %0d pos %0d last %0b ovf %0b"},
                                     want.value, want.position, want.last, want.overflow,
                                     got.value, got.position, got.last, got.overflow);
                    end
                end
            end

            if (start && !busy)
                expand_index(index_value);

            outstanding <= digits_due.size();
            mismatches <= error_cnt;
        end
    end

endmodule

FILE: dv/tb_index_to_radix_digits_core.sv
`timescale 1ns / 1ps

module tb_index_to_radix_digits_core;
    import idxrd_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int FINAL_SETTLE    = 20;
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(2);

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [IDX_W-1:0]   index_value = '0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;

    logic               busy;
    logic               result_valid;
    logic [RADIX_W-1:0] digit_value;
    logic [POS_W-1:0]   digit_position;
    logic               last_digit;
    logic               overflow_flag;
    logic [31:0]        prdata;
    logic               pready;

    int                 outstanding;
    int                 mismatches;
    int                 cycle_cnt = 0;
    int                 idle_pct = 0;
    logic [RADIX_W-1:0] radix_now = RADIX_RESET;

    index_to_radix_digits_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .index_value    (index_value),
        .result_valid   (result_valid),
        .digit_value    (digit_value),
        .digit_position (digit_position),
        .last_digit     (last_digit),
        .overflow_flag  (overflow_flag),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    radix_digit_checker i_digit_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .index_value    (index_value),
        .result_valid   (result_valid),
        .digit_value    (digit_value),
        .digit_position (digit_position),
        .last_digit     (last_digit),
        .overflow_flag  (overflow_flag),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .outstanding    (outstanding),
        .mismatches     (mismatches)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("index_to_radix_digits_core: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // start is redrawn every cycle, so the idle gaps land anywhere in the
    // block's run, including while it is busy and must ignore the request.
    task automatic issue_index(input logic [IDX_W-1:0] idx);
        index_value <= idx;
        do
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
        end
        while (!(start && !busy));
    endtask

    task automatic drain(input int settle);
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic [RADIX_W-1:0] radix_for_phase(input int p);
        case (p)
            0:       return 8'd255;
            1:       return 8'd0;
            2:       return 8'd1;
            3:       return 8'd3;
            4:       return 8'd10;
            5:       return 8'd16;
            6:       return 8'd2;
            9:       return 8'd254;
            default: return RADIX_W'($urandom_range(255));
        endcase
    endfunction

    // Mix of full-range, narrow and tiny indexes, all zeros or all ones, plus values right at the
    // point where the digits run out for the current radix.
    function automatic logic [IDX_W-1:0] pick_index(input logic [RADIX_W-1:0] radix);
        longint           span;
        int               base;
        logic [IDX_W-1:0] idx;
        base = (radix < RADIX_MIN) ? int'(RADIX_MIN) : int'(radix);
        span = 1;
        for (int k = 0; k < RUN_LEN && span <= 64'h7FFF_FFFF; k++)
            span = span * base;
        case ($urandom_range(5))
            0, 1:    idx = IDX_W'($urandom);
            2:       idx = IDX_W'($urandom) >> $urandom_range(IDX_W - 1);
            3:       idx = IDX_W'($urandom_range(255));
            4:
            begin
                if (span <= 64'h7FFF_FFFF)
                    idx = IDX_W'(span - 2 + $urandom_range(3));
                else
                    idx = '1 - IDX_W'($urandom_range(3));
            end
            default: idx = $urandom_range(1) ? '1 : '0;
        endcase
        return idx;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix of two: zero, all ones, one past and one short of the
        // eight-digit range, single top bit and alternating patterns.
        idle_pct = 10;
        issue_index('0);
        issue_index(IDX_W'(1));
        issue_index(IDX_W'(2));
        issue_index(IDX_W'(254));
        issue_index(IDX_W'(255));
        issue_index(IDX_W'(256));
        issue_index(IDX_W'(257));
        issue_index('1);
        issue_index(IDX_W'(1) << (IDX_W - 1));
        issue_index(31'h5555_5555);
        issue_index(31'h2AAA_AAAA);
        drain(4);

        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = (p < 4) ? 10 : ((p < 7) ? 53 : 0);
            radix_now = radix_for_phase(p);
            // Upper data bits are noise; only the low byte holds the radix.
            write_reg(ADDR_RADIX, ($urandom & 32'hFFFF_FF00) | 32'(radix_now));
            if (p == 3)
                write_reg(SPARE_ADDR, $urandom);
            issue_index('0);
            issue_index('1);
            issue_index((radix_now < RADIX_MIN) ? IDX_W'(1) : IDX_W'(radix_now - 1));
            repeat (ITEMS_PER_PHASE - 3)
                issue_index(pick_index(radix_now));
            drain(4);
        end
        repeat (FINAL_SETTLE) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("index_to_radix_digits_core: match");
        else
            $display("index_to_radix_digits_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/idxrd_pkg.sv
rtl/idxrd_divider.sv
rtl/index_to_radix_digits_core.sv
dv/radix_digit_checker.sv
dv/tb_index_to_radix_digits_core.sv
